[sv/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, widths, register codes and helpers for the stereo delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int LINE_DEPTH_DEF = 16384;

    localparam int SAMPLE_W   = 24;
    localparam int DELAY_W    = 15;
    localparam int COEF_W     = 16;
    localparam int GAIN_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int OPA_W  = SAMPLE_W + 1;
    localparam int OPB_W  = GAIN_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [COEF_W-1:0] FB_LIMIT = COEF_W'(62259);
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    localparam logic [DELAY_W-1:0] DELAY_LEFT_RST  = DELAY_W'(12000);
    localparam logic [DELAY_W-1:0] DELAY_RIGHT_RST = DELAY_W'(12500);
    localparam logic [COEF_W-1:0]  FEEDBACK_RST    = COEF_W'(26214);
    localparam logic [GAIN_W-1:0]  DRY_RST         = GAIN_W'(45875);
    localparam logic [GAIN_W-1:0]  WET_RST         = GAIN_W'(32768);
    localparam logic [COEF_W-1:0]  FILTER_RST      = COEF_W'(19661);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_LEFT    = 3'd0,
        REG_DELAY_RIGHT   = 3'd1,
        REG_FEEDBACK_GAIN = 3'd2,
        REG_DRY_GAIN      = 3'd3,
        REG_WET_GAIN      = 3'd4,
        REG_FILTER_COEFF  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CALC
    } state_t;

    // multiplier issue slots; each slot after the first also retires the product of the slot before
    typedef enum logic [2:0] {
        STEP_LP_L  = 3'd0,
        STEP_LP_R  = 3'd1,
        STEP_FB_L  = 3'd2,
        STEP_FB_R  = 3'd3,
        STEP_DRY   = 3'd4,
        STEP_WET_L = 3'd5,
        STEP_WET_R = 3'd6,
        STEP_LAST  = 3'd7
    } step_t;

    typedef struct packed {
        logic  rd_en;
        logic  load_delayed;
        logic  calc;
        step_t step;
        logic  finish;
    } ctrl_t;

    function automatic logic [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-SAMPLE_W:0] top;
        logic [SAMPLE_W-1:0]     res;
        top = v[SUM_W-1:SAMPLE_W-1];
        if ((top == '0) || (top == '1)) begin
            res = v[SAMPLE_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

[sv/sfd_ram.sv]
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/sfd_mul.sv]
// ----------------------------------------------------------------------------
// sfd_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module sfd_mul (
    input  logic                                aclk,
    input  logic signed [sfd_pkg::OPA_W-1:0]    a,
    input  logic signed [sfd_pkg::OPB_W-1:0]    b,
    output logic signed [sfd_pkg::PROD_W-1:0]   p
);

    logic signed [sfd_pkg::PROD_W-1:0] p_reg;
    logic signed [sfd_pkg::PROD_W-1:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

[sv/sfd_ctrl.sv]
// ----------------------------------------------------------------------------
// sfd_ctrl
// Sequencer: accept, line fetch, eight multiplier slots, result handoff.
// ----------------------------------------------------------------------------
module sfd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           out_free,
    output sfd_pkg::ctrl_t ctl
);

    sfd_pkg::state_t state_reg, state_next;
    sfd_pkg::step_t  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfd_pkg::ST_IDLE;
            step_reg  <= sfd_pkg::STEP_LP_L;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        s_tready         = 1'b0;
        ctl.rd_en        = 1'b0;
        ctl.load_delayed = 1'b0;
        ctl.calc         = 1'b0;
        ctl.step         = step_reg;
        ctl.finish       = 1'b0;
        case (state_reg)
            sfd_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                ctl.rd_en = s_tvalid;
                if (s_tvalid) begin
                    state_next = sfd_pkg::ST_FETCH;
                end
            end
            sfd_pkg::ST_FETCH: begin
                ctl.load_delayed = 1'b1;
                state_next       = sfd_pkg::ST_CALC;
                step_next        = sfd_pkg::STEP_LP_L;
            end
            sfd_pkg::ST_CALC: begin
                ctl.calc = 1'b1;
                if (step_reg != sfd_pkg::STEP_LAST) begin
                    step_next = sfd_pkg::step_t'(step_reg + 3'd1);
                end else if (out_free) begin
                    ctl.finish = 1'b1;
                    state_next = sfd_pkg::ST_IDLE;
                    step_next  = sfd_pkg::STEP_LP_L;
                end
            end
            default: begin
                state_next = sfd_pkg::ST_IDLE;
                step_next  = sfd_pkg::STEP_LP_L;
            end
        endcase
    end

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.finish |-> out_free)
        else $error("result retired into a busy output register");

    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sfd_pkg::ST_CALC) |-> (step_reg == sfd_pkg::STEP_LP_L))
        else $error("step counter left running outside calc");

    a_fetch_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sfd_pkg::ST_FETCH) |=>
            (state_reg == sfd_pkg::ST_CALC && step_reg == sfd_pkg::STEP_LP_L))
        else $error("fetch not followed by first calc slot");

endmodule

[sv/stereo_feedback_delay.sv]
// ----------------------------------------------------------------------------
// stereo_feedback_delay
// Mono-in, stereo-out feedback delay with one-pole lowpass in the loop.
//
//   channel  ports                 beat contents (lsb first)
//   in       s_tvalid/s_tready     s_tdata: sample_in[23:0]
//   out      m_tvalid/m_tready     m_tdata: left_out[23:0], right_out[47:24]
//   config   cfg_valid/cfg_ready   cfg_index: register, cfg_data: value
//
// A sample passes from accept through one line fetch and eight
// slots of the single shared 25x18 multiplier (seven products).
// The next sample is accepted the cycle after the result is registered.
// The result waits in the output register; it stalls the sequencer only
// when a new result is ready before the old one is taken.
// Reset: lines need no clearing pass; a wrap flag and the write pointer
// mark which entries are written, unwritten entries read as zero.
// ----------------------------------------------------------------------------
module stereo_feedback_delay #(
    parameter int LINE_DEPTH = sfd_pkg::LINE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sfd_pkg::SAMPLE_W-1:0]       s_tdata,    // sample_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [2*sfd_pkg::SAMPLE_W-1:0]     m_tdata,    // left_out, right_out
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = (((AW + 1) > sfd_pkg::DELAY_W) ? (AW + 1) : sfd_pkg::DELAY_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
    localparam logic [AW-1:0] WP_LAST = AW'(LINE_DEPTH - 1);
    localparam int SW = sfd_pkg::SAMPLE_W;
    localparam int FW = sfd_pkg::FRAC_W;
    localparam int PW = sfd_pkg::PROD_W;
    localparam int UW = sfd_pkg::SUM_W;

    function automatic logic [AW-1:0] line_rd_idx(input logic [AW-1:0] wp,
                                                  input logic [sfd_pkg::DELAY_W-1:0] dly);
        logic [CW-1:0] d_ext;
        logic [CW-1:0] d_eff;
        logic [CW-1:0] diff;
        d_ext = CW'(dly);
        d_eff = (d_ext > DEPTH_C) ? DEPTH_C : d_ext;
        diff  = CW'(wp) - d_eff;
        if (diff[CW-1]) begin
            diff = diff + DEPTH_C;
        end
        return diff[AW-1:0];
    endfunction

    // configuration
    logic [sfd_pkg::DELAY_W-1:0] delay_left_reg, delay_right_reg;
    logic [sfd_pkg::COEF_W-1:0]  feedback_gain_reg, filter_coeff_reg;
    logic [sfd_pkg::GAIN_W-1:0]  dry_gain_reg, wet_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_left_reg    <= sfd_pkg::DELAY_LEFT_RST;
            delay_right_reg   <= sfd_pkg::DELAY_RIGHT_RST;
            feedback_gain_reg <= sfd_pkg::FEEDBACK_RST;
            dry_gain_reg      <= sfd_pkg::DRY_RST;
            wet_gain_reg      <= sfd_pkg::WET_RST;
            filter_coeff_reg  <= sfd_pkg::FILTER_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sfd_pkg::REG_DELAY_LEFT:    delay_left_reg    <= cfg_data[sfd_pkg::DELAY_W-1:0];
                sfd_pkg::REG_DELAY_RIGHT:   delay_right_reg   <= cfg_data[sfd_pkg::DELAY_W-1:0];
                sfd_pkg::REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data[sfd_pkg::COEF_W-1:0];
                sfd_pkg::REG_DRY_GAIN:      dry_gain_reg      <= cfg_data[sfd_pkg::GAIN_W-1:0];
                sfd_pkg::REG_WET_GAIN:      wet_gain_reg      <= cfg_data[sfd_pkg::GAIN_W-1:0];
                sfd_pkg::REG_FILTER_COEFF:  filter_coeff_reg  <= cfg_data[sfd_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    logic [sfd_pkg::COEF_W-1:0] fb_eff;
    logic [sfd_pkg::GAIN_W-1:0] dry_eff, wet_eff;

    assign fb_eff  = (feedback_gain_reg > sfd_pkg::FB_LIMIT) ? sfd_pkg::FB_LIMIT
                                                             : feedback_gain_reg;
    assign dry_eff = (dry_gain_reg > sfd_pkg::GAIN_ONE) ? sfd_pkg::GAIN_ONE : dry_gain_reg;
    assign wet_eff = (wet_gain_reg > sfd_pkg::GAIN_ONE) ? sfd_pkg::GAIN_ONE : wet_gain_reg;

    // sequencer
    sfd_pkg::ctrl_t ctl;
    logic           out_free;
    logic           m_tvalid_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    sfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .ctl      (ctl)
    );

    // write pointer and line fill tracking
    logic [AW-1:0] wp_reg;
    logic          wrapped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else if (ctl.finish) begin
            if (wp_reg == WP_LAST) begin
                wp_reg      <= '0;
                wrapped_reg <= 1'b1;
            end else begin
                wp_reg <= wp_reg + AW'(1);
            end
        end
    end

    logic [AW-1:0] rd_idx_l, rd_idx_r;
    logic          rd_ok_l, rd_ok_r;

    assign rd_idx_l = line_rd_idx(wp_reg, delay_left_reg);
    assign rd_idx_r = line_rd_idx(wp_reg, delay_right_reg);
    assign rd_ok_l  = wrapped_reg || (rd_idx_l < wp_reg);
    assign rd_ok_r  = wrapped_reg || (rd_idx_r < wp_reg);

    // delay lines
    logic          we_l, we_r;
    logic [SW-1:0] wr_data;
    logic [SW-1:0] q_l, q_r;

    sfd_ram #(.WIDTH(SW), .DEPTH(LINE_DEPTH)) u_line_l (
        .aclk  (aclk),
        .we    (we_l),
        .waddr (wp_reg),
        .wdata (wr_data),
        .re    (ctl.rd_en),
        .raddr (rd_idx_l),
        .rdata (q_l)
    );

    sfd_ram #(.WIDTH(SW), .DEPTH(LINE_DEPTH)) u_line_r (
        .aclk  (aclk),
        .we    (we_r),
        .waddr (wp_reg),
        .wdata (wr_data),
        .re    (ctl.rd_en),
        .raddr (rd_idx_r),
        .rdata (q_r)
    );

    // sample and delayed taps
    logic [SW-1:0] x_reg, dl_reg, dr_reg;
    logic          ok_l_reg, ok_r_reg;

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            x_reg    <= s_tdata;
            ok_l_reg <= rd_ok_l;
            ok_r_reg <= rd_ok_r;
        end
        if (ctl.load_delayed) begin
            dl_reg <= ok_l_reg ? q_l : '0;
            dr_reg <= ok_r_reg ? q_r : '0;
        end
    end

    // shared multiplier
    logic signed [sfd_pkg::OPA_W-1:0] mul_a;
    logic signed [sfd_pkg::OPB_W-1:0] mul_b;
    logic signed [PW-1:0]             prod;
    logic [SW-1:0]                    lpl_reg, lpr_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.step)
            sfd_pkg::STEP_LP_L: begin
                mul_a = $signed({dl_reg[SW-1], dl_reg}) - $signed({lpl_reg[SW-1], lpl_reg});
                mul_b = $signed({2'b00, filter_coeff_reg});
            end
            sfd_pkg::STEP_LP_R: begin
                mul_a = $signed({dr_reg[SW-1], dr_reg}) - $signed({lpr_reg[SW-1], lpr_reg});
                mul_b = $signed({2'b00, filter_coeff_reg});
            end
            sfd_pkg::STEP_FB_L: begin
                mul_a = $signed({lpl_reg[SW-1], lpl_reg});
                mul_b = $signed({2'b00, fb_eff});
            end
            sfd_pkg::STEP_FB_R: begin
                mul_a = $signed({lpr_reg[SW-1], lpr_reg});
                mul_b = $signed({2'b00, fb_eff});
            end
            sfd_pkg::STEP_DRY: begin
                mul_a = $signed({x_reg[SW-1], x_reg});
                mul_b = $signed({1'b0, dry_eff});
            end
            sfd_pkg::STEP_WET_L: begin
                mul_a = $signed({dl_reg[SW-1], dl_reg});
                mul_b = $signed({1'b0, wet_eff});
            end
            // operands held in the last slot so the right wet product survives a stall
            sfd_pkg::STEP_WET_R, sfd_pkg::STEP_LAST: begin
                mul_a = $signed({dr_reg[SW-1], dr_reg});
                mul_b = $signed({1'b0, wet_eff});
            end
            default: ;
        endcase
    end

    sfd_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    // retire the product issued in the previous slot
    logic [SW-1:0]        prod_lp;
    logic signed [UW-1:0] fb_sum;
    logic signed [UW-1:0] mix_sum;
    logic signed [UW-1:0] mix_sh;
    logic [SW-1:0]        mix_sat;
    logic signed [PW-1:0] dry_reg;
    logic [SW-1:0]        out_l_reg;
    logic [2*SW-1:0]      m_tdata_reg;

    // lowpass moves between its old value and the tap, so it stays in 24 bits
    assign prod_lp = prod[FW+SW-1:FW];
    assign fb_sum  = $signed({{(UW-SW){x_reg[SW-1]}}, x_reg})
                   + $signed({{(FW+1){prod[PW-1]}}, prod[PW-1:FW]});
    assign wr_data = sfd_pkg::sat24(fb_sum);
    assign mix_sum = $signed({dry_reg[PW-1], dry_reg}) + $signed({prod[PW-1], prod});
    assign mix_sh  = $signed({{FW{mix_sum[UW-1]}}, mix_sum[UW-1:FW]});
    assign mix_sat = sfd_pkg::sat24(mix_sh);

    assign we_l = ctl.calc && (ctl.step == sfd_pkg::STEP_FB_R);
    assign we_r = ctl.calc && (ctl.step == sfd_pkg::STEP_DRY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lpl_reg <= '0;
            lpr_reg <= '0;
        end else if (ctl.calc) begin
            if (ctl.step == sfd_pkg::STEP_LP_R) begin
                lpl_reg <= lpl_reg + prod_lp;
            end
            if (ctl.step == sfd_pkg::STEP_FB_L) begin
                lpr_reg <= lpr_reg + prod_lp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.calc && (ctl.step == sfd_pkg::STEP_WET_L)) begin
            dry_reg <= prod;
        end
        if (ctl.calc && (ctl.step == sfd_pkg::STEP_WET_R)) begin
            out_l_reg <= mix_sat;
        end
        if (ctl.finish) begin
            m_tdata_reg <= {mix_sat, out_l_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= WP_LAST)
        else $error("write pointer beyond line depth");

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(we_l && we_r))
        else $error("both lines written in one cycle");

    a_wp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg != $past(wp_reg)) |-> $past(ctl.finish))
        else $error("write pointer moved without a retired sample");

endmodule
